@@ hdl/srse_pkg.sv @@
// Shared constants, codes and handshake types of the sorted range set engine.
`timescale 1ns / 1ps

package srse_pkg;

    localparam int DATA_W    = 64;
    localparam int SEG_CAP   = 256;
    localparam int IDX_W     = $clog2(SEG_CAP);
    localparam int CNT_W     = $clog2(SEG_CAP + 1);
    localparam int HIST_BINS = 64;
    localparam int HBIN_W    = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int HCNT_W    = CNT_W;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_CLEAR    = 3'd2;
    localparam logic [2:0] ACT_CONTAINS = 3'd3;
    localparam logic [2:0] ACT_LBOUND   = 3'd4;
    localparam logic [2:0] ACT_HIST     = 3'd5;
    localparam logic [2:0] ACT_VACATE   = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERLAP   = 3'd1;
    localparam logic [2:0] ST_UNTRACKED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BADSIZE   = 3'd4;

    localparam logic [1:0] HOP_INC  = 2'd0;
    localparam logic [1:0] HOP_DEC  = 2'd1;
    localparam logic [1:0] HOP_PEEK = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [DATA_W-1:0] size;
        logic [HBIN_W-1:0] bin;
        logic              clr;
    } hist_req_t;

    typedef struct packed {
        logic              busy;
        logic              peek_valid;
        logic [HCNT_W-1:0] count;
    } hist_rsp_t;

endpackage

@@ hdl/srse_ram.sv @@
// Generic single-clock RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module srse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/srse_hist.sv @@
// Size histogram: bin memory with valid bits and a read-modify-write pipeline.
`timescale 1ns / 1ps

module srse_hist (
    input  logic                aclk,
    input  logic                aresetn,
    input  srse_pkg::hist_req_t req,
    output srse_pkg::hist_rsp_t rsp
);

    logic                          a_v_reg;
    logic [1:0]                    a_op_reg;
    logic [srse_pkg::DATA_W-1:0]   a_size_reg;
    logic [srse_pkg::HBIN_W-1:0]   a_bin_reg;
    logic                          b_v_reg;
    logic [1:0]                    b_op_reg;
    logic [srse_pkg::HBIN_W-1:0]   b_bin_reg;
    logic                          lw_v_reg;
    logic [srse_pkg::HBIN_W-1:0]   lw_bin_reg;
    logic [srse_pkg::HCNT_W-1:0]   lw_cnt_reg;
    logic [srse_pkg::HIST_BINS-1:0] hv_reg;

    logic [srse_pkg::HBIN_W-1:0]   a_sel;
    logic [srse_pkg::HCNT_W-1:0]   rdata;
    logic [srse_pkg::HCNT_W-1:0]   base;
    logic [srse_pkg::HCNT_W-1:0]   upd;
    logic                          we;

    // floor(log2 x); zero maps to bin zero
    function automatic logic [5:0] lead_one(input logic [63:0] x);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 1; i < 64; i++) begin
            if (x[i]) r = 6'(i);
        end
        return r;
    endfunction

    always_comb begin
        logic [5:0] l;
        l = lead_one(a_size_reg);
        if (a_op_reg == srse_pkg::HOP_PEEK) begin
            a_sel = a_bin_reg;
        end else if (int'(l) >= srse_pkg::HIST_BINS) begin
            a_sel = srse_pkg::HBIN_W'(srse_pkg::HIST_BINS - 1);
        end else begin
            a_sel = srse_pkg::HBIN_W'(l);
        end
    end

    always_comb begin
        if (lw_v_reg && lw_bin_reg == b_bin_reg) begin
            base = lw_cnt_reg;
        end else if (hv_reg[b_bin_reg]) begin
            base = rdata;
        end else begin
            base = '0;
        end
        case (b_op_reg)
            srse_pkg::HOP_INC: upd = base + srse_pkg::HCNT_W'(1);
            srse_pkg::HOP_DEC: upd = (base != '0) ? base - srse_pkg::HCNT_W'(1) : base;
            default:           upd = base;
        endcase
        we = b_v_reg && (b_op_reg != srse_pkg::HOP_PEEK);
    end

    srse_ram #(
        .WIDTH(srse_pkg::HCNT_W),
        .DEPTH(srse_pkg::HIST_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (we),
        .waddr (b_bin_reg),
        .wdata (upd),
        .re    (a_v_reg),
        .raddr (a_sel),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            lw_v_reg <= 1'b0;
            hv_reg   <= '0;
        end else begin
            a_v_reg    <= req.valid;
            a_op_reg   <= req.op;
            a_size_reg <= req.size;
            a_bin_reg  <= req.bin;
            b_v_reg    <= a_v_reg;
            b_op_reg   <= a_op_reg;
            b_bin_reg  <= a_sel;
            if (we) begin
                hv_reg[b_bin_reg] <= 1'b1;
                lw_v_reg          <= 1'b1;
                lw_bin_reg        <= b_bin_reg;
                lw_cnt_reg        <= upd;
            end
            if (req.clr) begin
                hv_reg   <= '0;
                lw_v_reg <= 1'b0;
            end
        end
    end

    assign rsp.busy       = a_v_reg || b_v_reg;
    assign rsp.peek_valid = b_v_reg && (b_op_reg == srse_pkg::HOP_PEEK);
    assign rsp.count      = base;

endmodule

@@ hdl/sorted_range_set_engine.sv @@
// Top level of the sorted range set engine: request sequencer and segment memories.
`timescale 1ns / 1ps

// Holds up to 256 disjoint half-open ranges sorted by start, in two segment
// memories (starts and ends) with one read and one write port each, plus a
// 64-bin size histogram, the covered space and the segment count. Every
// transaction first scans the used entries, one per cycle, and then a
// decision state settles the status. Add, remove and clear (of a non-empty
// range) that succeed then stream the table once more, rewriting it in place:
// each entry is written out once when kept or changed, twice when split or
// preceded by an inserted range, and not at all when dropped. Histogram
// updates run in a read-modify-write pipe that must drain before the result
// is given; the single read port of the segment memories sets the pace of
// both passes. A new transaction is taken as soon as the previous one has
// finished, even while its result still waits in the output register.
module sorted_range_set_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [63:0] s_range_start,
    input  logic [63:0] s_range_size,
    input  logic [5:0]  s_bin_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [63:0] m_found_start,
    output logic [63:0] m_found_size,
    output logic [8:0]  m_bin_count,
    output logic [63:0] m_total_space,
    output logic [8:0]  m_segment_count
);

    localparam int CW = srse_pkg::CNT_W;
    localparam int IW = srse_pkg::IDX_W;
    localparam int DW = srse_pkg::DATA_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_PINIT = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]    state_reg;

    // current transaction
    logic [2:0]    act_reg;
    logic [DW-1:0] rng_start_reg;
    logic [DW-1:0] rng_size_reg;
    logic [DW-1:0] rng_end_reg;
    logic          ovf_reg;
    logic [5:0]    bin_reg;

    // table state
    logic [CW-1:0] n_reg;
    logic [DW-1:0] cov_reg;

    // scan
    logic [CW-1:0] rd_idx_reg;
    logic          dv_reg;
    logic [CW-1:0] dv_idx_reg;
    logic          ovl_reg;
    logic          hl_reg;
    logic          hr_reg;
    logic [CW-1:0] l_idx_reg;
    logic [CW-1:0] r_idx_reg;
    logic [DW-1:0] rend_reg;
    logic          pf_reg;
    logic [CW-1:0] p_idx_reg;
    logic          lbf_reg;
    logic [DW-1:0] lbs_reg;
    logic [DW-1:0] lbz_reg;
    logic          rmf_reg;
    logic          rsplit_reg;
    logic [CW:0]   need_reg;

    // rewrite pass
    logic          cut_reg;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] w_reg;
    logic [DW-1:0] o_s_reg [2];
    logic [DW-1:0] o_e_reg [2];
    logic          o_new_reg [2];
    logic [1:0]    o_cnt_reg;
    logic          k_reg;
    logic          tail_done_reg;
    logic          cpend_reg;
    logic [DW-1:0] camt_reg;

    // result
    logic [2:0]    res_status_reg;
    logic          res_found_reg;
    logic [DW-1:0] res_fs_reg;
    logic [DW-1:0] res_fz_reg;
    logic [srse_pkg::HCNT_W-1:0] res_bc_reg;

    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic          m_found_reg;
    logic [63:0]   m_found_start_reg;
    logic [63:0]   m_found_size_reg;
    logic [8:0]    m_bin_count_reg;
    logic [63:0]   m_total_space_reg;
    logic [8:0]    m_segment_count_reg;

    // memory ports
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic          ram_we;
    logic [DW-1:0] rd_s;
    logic [DW-1:0] rd_e;

    srse_pkg::hist_req_t hreq;
    srse_pkg::hist_rsp_t hrsp;

    logic [CW-1:0] r_inc;
    logic          r_live;
    logic          ins;

    // per-entry rewrite decision
    logic [DW-1:0] ev_s0, ev_e0, ev_s1, ev_e1;
    logic          ev_new0, ev_new1;
    logic [1:0]    ev_cnt;
    logic          ev_sub;
    logic          ev_ov;
    logic [DW-1:0] ev_amt;

    // scan compares
    logic          sc_ov;
    logic [1:0]    sc_inc;

    logic          size_zero;
    logic          full;

    assign size_zero = (rng_size_reg == '0);
    assign full      = (n_reg >= CW'(srse_pkg::SEG_CAP));
    assign r_inc     = r_reg + CW'(1);
    assign r_live    = (r_reg < n_reg);
    assign ins       = !hl_reg && !hr_reg;
    assign s_ready   = (state_reg == S_IDLE);

    srse_ram #(.WIDTH(DW), .DEPTH(srse_pkg::SEG_CAP)) u_starts (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (w_reg[IW-1:0]),
        .wdata (o_s_reg[k_reg]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_s)
    );

    srse_ram #(.WIDTH(DW), .DEPTH(srse_pkg::SEG_CAP)) u_ends (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (w_reg[IW-1:0]),
        .wdata (o_e_reg[k_reg]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_e)
    );

    srse_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .rsp     (hrsp)
    );

    // Memory address and histogram request steering.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        hreq.valid = 1'b0;
        hreq.op    = srse_pkg::HOP_INC;
        hreq.size  = '0;
        hreq.bin   = srse_pkg::HBIN_W'(bin_reg);
        hreq.clr   = 1'b0;
        unique case (state_reg)
            S_SCAN: begin
                ram_re    = (rd_idx_reg < n_reg);
                ram_raddr = rd_idx_reg[IW-1:0];
            end
            S_PINIT: begin
                ram_re = (n_reg != '0);
            end
            S_EV: begin
                // prefetch the next entry before any write can land on it
                ram_re    = r_live && (r_inc < n_reg);
                ram_raddr = r_inc[IW-1:0];
                if (r_live && ev_sub) begin
                    hreq.valid = 1'b1;
                    hreq.op    = srse_pkg::HOP_DEC;
                    hreq.size  = rd_e - rd_s;
                end
            end
            S_WR: begin
                ram_we = 1'b1;
                if (o_new_reg[k_reg]) begin
                    hreq.valid = 1'b1;
                    hreq.op    = srse_pkg::HOP_INC;
                    hreq.size  = o_e_reg[k_reg] - o_s_reg[k_reg];
                end
            end
            S_DEC: begin
                if (act_reg == srse_pkg::ACT_HIST &&
                    {1'b0, bin_reg} < 7'(srse_pkg::HIST_BINS)) begin
                    hreq.valid = 1'b1;
                    hreq.op    = srse_pkg::HOP_PEEK;
                end
                hreq.clr = (act_reg == srse_pkg::ACT_VACATE);
            end
            default: begin
            end
        endcase
    end

    // Scan compares for the entry whose data just came back.
    always_comb begin
        sc_ov  = (rng_start_reg < rd_e) && (rng_end_reg > rd_s);
        sc_inc = sc_ov ? ({1'b0, rd_s < rng_start_reg} + {1'b0, rd_e > rng_end_reg}) : 2'd1;
    end

    // Rewrite decision for the current entry.
    always_comb begin
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        ev_s0   = rd_s;
        ev_e0   = rd_e;
        ev_new0 = 1'b0;
        ev_s1   = rd_s;
        ev_e1   = rd_e;
        ev_new1 = 1'b0;
        ev_cnt  = 2'd1;
        ev_sub  = 1'b0;
        ev_ov   = (rd_s < rng_end_reg) && (rd_e > rng_start_reg);
        lo      = (rd_s > rng_start_reg) ? rd_s : rng_start_reg;
        hi      = (rd_e < rng_end_reg) ? rd_e : rng_end_reg;
        ev_amt  = hi - lo;
        if (cut_reg) begin
            if (ev_ov) begin
                // trim or split the overlapped entry, drop it when covered
                ev_sub = 1'b1;
                ev_cnt = 2'd0;
                if (rd_s < rng_start_reg) begin
                    ev_e0   = rng_start_reg;
                    ev_new0 = 1'b1;
                    ev_cnt  = 2'd1;
                end
                if (rd_e > rng_end_reg) begin
                    if (rd_s < rng_start_reg) begin
                        ev_s1   = rng_end_reg;
                        ev_new1 = 1'b1;
                        ev_cnt  = 2'd2;
                    end else begin
                        ev_s0   = rng_end_reg;
                        ev_new0 = 1'b1;
                        ev_cnt  = 2'd1;
                    end
                end
            end
        end else if (hl_reg && r_reg == l_idx_reg) begin
            ev_e0   = hr_reg ? rend_reg : rng_end_reg;
            ev_new0 = 1'b1;
            ev_sub  = 1'b1;
        end else if (hr_reg && r_reg == r_idx_reg) begin
            ev_sub = 1'b1;
            if (hl_reg) begin
                ev_cnt = 2'd0;
            end else begin
                ev_s0   = rng_start_reg;
                ev_new0 = 1'b1;
            end
        end else if (ins && r_reg == p_idx_reg) begin
            ev_s0   = rng_start_reg;
            ev_e0   = rng_end_reg;
            ev_new0 = 1'b1;
            ev_cnt  = 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            n_reg       <= '0;
            cov_reg     <= '0;
            cpend_reg   <= 1'b0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // apply the space taken by the last cut entry
            if (cpend_reg) begin
                cov_reg   <= cov_reg - camt_reg;
                cpend_reg <= 1'b0;
            end
            if (hrsp.peek_valid) begin
                res_bc_reg <= hrsp.count;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        {ovf_reg, rng_end_reg} <= {1'b0, s_range_start} + {1'b0, s_range_size};
                        act_reg       <= s_action;
                        rng_start_reg <= s_range_start;
                        rng_size_reg  <= s_range_size;
                        bin_reg       <= s_bin_index;
                        rd_idx_reg    <= '0;
                        dv_reg        <= 1'b0;
                        ovl_reg       <= 1'b0;
                        hl_reg        <= 1'b0;
                        hr_reg        <= 1'b0;
                        pf_reg        <= 1'b0;
                        p_idx_reg     <= n_reg;
                        lbf_reg       <= 1'b0;
                        rmf_reg       <= 1'b0;
                        rsplit_reg    <= 1'b0;
                        need_reg      <= '0;
                        res_bc_reg    <= '0;
                        state_reg     <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (ram_re) begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                    dv_reg     <= ram_re;
                    dv_idx_reg <= rd_idx_reg;
                    if (dv_reg) begin
                        if (sc_ov) begin
                            ovl_reg <= 1'b1;
                        end
                        if (rd_e == rng_start_reg) begin
                            hl_reg    <= 1'b1;
                            l_idx_reg <= dv_idx_reg;
                        end
                        if (rd_s == rng_end_reg) begin
                            hr_reg    <= 1'b1;
                            r_idx_reg <= dv_idx_reg;
                            rend_reg  <= rd_e;
                        end
                        if (!pf_reg && rd_s > rng_start_reg) begin
                            pf_reg    <= 1'b1;
                            p_idx_reg <= dv_idx_reg;
                        end
                        if (!lbf_reg && rd_s >= rng_start_reg) begin
                            lbf_reg <= 1'b1;
                            lbs_reg <= rd_s;
                            lbz_reg <= rd_e - rd_s;
                        end
                        if (!rmf_reg && rng_start_reg >= rd_s && rng_end_reg <= rd_e) begin
                            rmf_reg    <= 1'b1;
                            rsplit_reg <= (rng_start_reg > rd_s) && (rng_end_reg < rd_e);
                        end
                        need_reg <= need_reg + (CW + 1)'(sc_inc);
                    end
                    if (!ram_re && !dv_reg) begin
                        state_reg <= S_DEC;
                    end
                end

                S_DEC: begin
                    res_status_reg <= srse_pkg::ST_OK;
                    res_found_reg  <= 1'b0;
                    res_fs_reg     <= '0;
                    res_fz_reg     <= '0;
                    r_reg          <= '0;
                    w_reg          <= '0;
                    tail_done_reg  <= 1'b0;
                    state_reg      <= S_FIN;
                    unique case (act_reg)
                        srse_pkg::ACT_ADD: begin
                            cut_reg <= 1'b0;
                            if (size_zero || ovf_reg) begin
                                res_status_reg <= srse_pkg::ST_BADSIZE;
                            end else if (ovl_reg) begin
                                res_status_reg <= srse_pkg::ST_OVERLAP;
                            end else if (ins && full) begin
                                res_status_reg <= srse_pkg::ST_FULL;
                            end else begin
                                cov_reg   <= cov_reg + rng_size_reg;
                                state_reg <= S_PINIT;
                            end
                        end
                        srse_pkg::ACT_REMOVE: begin
                            cut_reg <= 1'b1;
                            if (size_zero || ovf_reg) begin
                                res_status_reg <= srse_pkg::ST_BADSIZE;
                            end else if (!rmf_reg) begin
                                res_status_reg <= srse_pkg::ST_UNTRACKED;
                            end else if (rsplit_reg && full) begin
                                res_status_reg <= srse_pkg::ST_FULL;
                            end else begin
                                state_reg <= S_PINIT;
                            end
                        end
                        srse_pkg::ACT_CLEAR: begin
                            cut_reg <= 1'b1;
                            if (ovf_reg) begin
                                res_status_reg <= srse_pkg::ST_BADSIZE;
                            end else if (!size_zero) begin
                                if (need_reg > (CW + 1)'(srse_pkg::SEG_CAP)) begin
                                    res_status_reg <= srse_pkg::ST_FULL;
                                end else begin
                                    state_reg <= S_PINIT;
                                end
                            end
                        end
                        srse_pkg::ACT_CONTAINS: begin
                            if (ovf_reg) begin
                                res_status_reg <= srse_pkg::ST_BADSIZE;
                            end else begin
                                res_found_reg <= ovl_reg;
                            end
                        end
                        srse_pkg::ACT_LBOUND: begin
                            res_found_reg <= lbf_reg;
                            if (lbf_reg) begin
                                res_fs_reg <= lbs_reg;
                                res_fz_reg <= lbz_reg;
                            end
                        end
                        srse_pkg::ACT_VACATE: begin
                            n_reg   <= '0;
                            cov_reg <= '0;
                        end
                        default: begin
                        end
                    endcase
                end

                S_PINIT: begin
                    state_reg <= S_EV;
                end

                S_EV: begin
                    k_reg <= 1'b0;
                    if (r_live) begin
                        o_s_reg[0]   <= ev_s0;
                        o_e_reg[0]   <= ev_e0;
                        o_new_reg[0] <= ev_new0;
                        o_s_reg[1]   <= ev_s1;
                        o_e_reg[1]   <= ev_e1;
                        o_new_reg[1] <= ev_new1;
                        o_cnt_reg    <= ev_cnt;
                        r_reg        <= r_inc;
                        if (cut_reg && ev_ov) begin
                            cpend_reg <= 1'b1;
                            camt_reg  <= ev_amt;
                        end
                        state_reg <= (ev_cnt != 2'd0) ? S_WR : S_EV;
                    end else if (!cut_reg && ins && p_idx_reg == n_reg && !tail_done_reg) begin
                        // append after the last entry
                        o_s_reg[0]    <= rng_start_reg;
                        o_e_reg[0]    <= rng_end_reg;
                        o_new_reg[0]  <= 1'b1;
                        o_cnt_reg     <= 2'd1;
                        tail_done_reg <= 1'b1;
                        state_reg     <= S_WR;
                    end else begin
                        n_reg     <= w_reg;
                        state_reg <= S_FIN;
                    end
                end

                S_WR: begin
                    w_reg <= w_reg + CW'(1);
                    if (o_cnt_reg == 2'd2 && !k_reg) begin
                        k_reg <= 1'b1;
                    end else begin
                        state_reg <= S_EV;
                    end
                end

                S_FIN: begin
                    // hold until histogram and space updates settle and the output register is free
                    if (!hrsp.busy && !cpend_reg && (!m_valid_reg || m_ready)) begin
                        m_valid_reg         <= 1'b1;
                        m_status_reg        <= res_status_reg;
                        m_found_reg         <= res_found_reg;
                        m_found_start_reg   <= res_fs_reg;
                        m_found_size_reg    <= res_fz_reg;
                        m_bin_count_reg     <= 9'(res_bc_reg);
                        m_total_space_reg   <= cov_reg;
                        m_segment_count_reg <= 9'(n_reg);
                        state_reg           <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found         = m_found_reg;
    assign m_found_start   = m_found_start_reg;
    assign m_found_size    = m_found_size_reg;
    assign m_bin_count     = m_bin_count_reg;
    assign m_total_space   = m_total_space_reg;
    assign m_segment_count = m_segment_count_reg;

endmodule

@@ test/sorted_range_set_engine_tb.sv @@
// Testbench for the sorted range set engine: random and directed requests checked by a predictor.
`timescale 1ns / 1ps

module sorted_range_set_engine_tb;

    // Action code 7 has no name in the package; the block treats it as a no-op.
    localparam logic [2:0] ACT_NOP = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [2:0]  action;
        logic [63:0] start;
        logic [63:0] size;
        logic [5:0]  bin;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [63:0] fstart;
        logic [63:0] fsize;
        logic [8:0]  bcount;
        logic [63:0] total;
        logic [8:0]  segcnt;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [63:0] s_range_start = '0;
    logic [63:0] s_range_size = '0;
    logic [5:0]  s_bin_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_found;
    logic [63:0] m_found_start;
    logic [63:0] m_found_size;
    logic [8:0]  m_bin_count;
    logic [63:0] m_total_space;
    logic [8:0]  m_segment_count;

    sorted_range_set_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_range_start(s_range_start), .s_range_size(s_range_size),
        .s_bin_index(s_bin_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_found(m_found),
        .m_found_start(m_found_start), .m_found_size(m_found_size),
        .m_bin_count(m_bin_count), .m_total_space(m_total_space),
        .m_segment_count(m_segment_count)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: mirror of the segment table, histogram and totals.
    // ------------------------------------------------------------------
    logic [63:0] seg_lo [srse_pkg::SEG_CAP];
    logic [63:0] seg_hi [srse_pkg::SEG_CAP];
    int unsigned seg_used;
    logic [63:0] covered;
    int unsigned size_hist [srse_pkg::HIST_BINS];

    request_t    pending_reqs [$];
    reply_t      expected_replies [$];
    int          reqs_total;
    int          reqs_sent;
    int          replies_seen;
    int          mismatches;
    bit          stim_done;

    function automatic int size_to_bin(logic [63:0] sz);
        int b;
        b = 0;
        while (b < 63 && (sz >> (b + 1)) != 0) b++;
        if (b >= srse_pkg::HIST_BINS) b = srse_pkg::HIST_BINS - 1;
        return b;
    endfunction

    function automatic void hist_inc(logic [63:0] sz);
        size_hist[size_to_bin(sz)]++;
    endfunction

    function automatic void hist_dec(logic [63:0] sz);
        int b;
        b = size_to_bin(sz);
        if (size_hist[b] != 0) size_hist[b]--;
    endfunction

    function automatic void table_insert(int idx, logic [63:0] lo, logic [63:0] hi);
        for (int k = seg_used; k > idx; k--) begin
            seg_lo[k] = seg_lo[k-1];
            seg_hi[k] = seg_hi[k-1];
        end
        seg_lo[idx] = lo;
        seg_hi[idx] = hi;
        seg_used++;
    endfunction

    function automatic void table_delete(int idx);
        for (int k = idx; k < seg_used - 1; k++) begin
            seg_lo[k] = seg_lo[k+1];
            seg_hi[k] = seg_hi[k+1];
        end
        seg_used--;
    endfunction

    function automatic logic [2:0] range_add(logic [63:0] lo, logic [63:0] hi, logic [63:0] sz);
        int left, right, k;
        bit has_l, has_r;
        left = 0; right = 0; has_l = 0; has_r = 0;
        for (k = 0; k < seg_used; k++) begin
            if (lo < seg_hi[k] && hi > seg_lo[k]) return srse_pkg::ST_OVERLAP;
            if (seg_hi[k] == lo) begin has_l = 1; left = k; end
            if (seg_lo[k] == hi) begin has_r = 1; right = k; end
        end
        if (has_l && has_r) begin
            hist_dec(seg_hi[left] - seg_lo[left]);
            hist_dec(seg_hi[right] - seg_lo[right]);
            seg_hi[left] = seg_hi[right];
            table_delete(right);
            hist_inc(seg_hi[left] - seg_lo[left]);
        end else if (has_l) begin
            hist_dec(seg_hi[left] - seg_lo[left]);
            seg_hi[left] = hi;
            hist_inc(hi - seg_lo[left]);
        end else if (has_r) begin
            hist_dec(seg_hi[right] - seg_lo[right]);
            seg_lo[right] = lo;
            hist_inc(seg_hi[right] - lo);
        end else begin
            if (seg_used >= srse_pkg::SEG_CAP) return srse_pkg::ST_FULL;
            for (k = 0; k < seg_used; k++)
                if (seg_lo[k] > lo) break;
            table_insert(k, lo, hi);
            hist_inc(sz);
        end
        covered += sz;
        return srse_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] range_remove(logic [63:0] lo, logic [63:0] hi,
                                                logic [63:0] sz);
        int k;
        logic [63:0] s, e;
        for (k = 0; k < seg_used; k++)
            if (lo >= seg_lo[k] && hi <= seg_hi[k]) break;
        if (k >= seg_used) return srse_pkg::ST_UNTRACKED;
        s = seg_lo[k];
        e = seg_hi[k];
        if (lo > s && hi < e && seg_used >= srse_pkg::SEG_CAP) return srse_pkg::ST_FULL;
        hist_dec(e - s);
        if (lo == s && hi == e) begin
            table_delete(k);
        end else if (lo == s) begin
            seg_lo[k] = hi;
            hist_inc(e - hi);
        end else if (hi == e) begin
            seg_hi[k] = lo;
            hist_inc(lo - s);
        end else begin
            seg_hi[k] = lo;
            table_insert(k + 1, hi, e);
            hist_inc(lo - s);
            hist_inc(e - hi);
        end
        covered -= sz;
        return srse_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] range_clear(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] nlo [srse_pkg::SEG_CAP+1];
        logic [63:0] nhi [srse_pkg::SEG_CAP+1];
        logic [63:0] s, e;
        int n, need;
        n = 0; need = 0;
        for (int k = 0; k < seg_used; k++) begin
            if (seg_lo[k] < hi && seg_hi[k] > lo)
                need += (seg_lo[k] < lo ? 1 : 0) + (seg_hi[k] > hi ? 1 : 0);
            else
                need++;
        end
        if (need > srse_pkg::SEG_CAP) return srse_pkg::ST_FULL;
        for (int k = 0; k < seg_used; k++) begin
            s = seg_lo[k];
            e = seg_hi[k];
            if (s < hi && e > lo) begin
                hist_dec(e - s);
                covered -= e - s;
                if (s < lo) begin
                    nlo[n] = s; nhi[n] = lo; n++;
                    hist_inc(lo - s);
                    covered += lo - s;
                end
                if (e > hi) begin
                    nlo[n] = hi; nhi[n] = e; n++;
                    hist_inc(e - hi);
                    covered += e - hi;
                end
            end else begin
                nlo[n] = s; nhi[n] = e; n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            seg_lo[k] = nlo[k];
            seg_hi[k] = nhi[k];
        end
        seg_used = n;
        return srse_pkg::ST_OK;
    endfunction

    // Work out the reply of one accepted request and advance the mirror.
    function automatic reply_t predict_reply(request_t rq);
        reply_t r;
        logic [63:0] hi;
        bit wraps;
        hi = rq.start + rq.size;
        wraps = hi < rq.start;
        r = '{default: '0};
        case (rq.action)
            srse_pkg::ACT_ADD:
                r.status = (rq.size == 0 || wraps) ? srse_pkg::ST_BADSIZE
                                                   : range_add(rq.start, hi, rq.size);
            srse_pkg::ACT_REMOVE:
                r.status = (rq.size == 0 || wraps) ? srse_pkg::ST_BADSIZE
                                                   : range_remove(rq.start, hi, rq.size);
            srse_pkg::ACT_CLEAR: begin
                if (wraps) r.status = srse_pkg::ST_BADSIZE;
                else if (rq.size != 0) r.status = range_clear(rq.start, hi);
            end
            srse_pkg::ACT_CONTAINS: begin
                if (wraps) begin
                    r.status = srse_pkg::ST_BADSIZE;
                end else begin
                    for (int k = 0; k < seg_used; k++)
                        if (seg_lo[k] < hi && seg_hi[k] > rq.start) begin
                            r.found = 1'b1;
                            break;
                        end
                end
            end
            srse_pkg::ACT_LBOUND: begin
                for (int k = 0; k < seg_used; k++)
                    if (seg_lo[k] >= rq.start) begin
                        r.found = 1'b1;
                        r.fstart = seg_lo[k];
                        r.fsize = seg_hi[k] - seg_lo[k];
                        break;
                    end
            end
            srse_pkg::ACT_HIST:
                if (rq.bin < srse_pkg::HIST_BINS) r.bcount = 9'(size_hist[rq.bin]);
            srse_pkg::ACT_VACATE: begin
                foreach (size_hist[b]) size_hist[b] = 0;
                seg_used = 0;
                covered = '0;
            end
            default: ;
        endcase
        r.total = covered;
        r.segcnt = 9'(seg_used);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_req(logic [2:0] act, logic [63:0] st, logic [63:0] sz,
                                      logic [5:0] bn);
        request_t rq;
        rq.action = act;
        rq.start = st;
        rq.size = sz;
        rq.bin = bn;
        pending_reqs.push_back(rq);
        reqs_total++;
    endfunction

    function automatic logic [63:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Mostly grid-aligned ranges so adds touch and merge; the rest is noise.
    function automatic void queue_random_req(logic [63:0] base);
        int p;
        logic [2:0] act;
        logic [63:0] st, sz;
        p = $urandom_range(0, 99);
        if (p < 40) act = srse_pkg::ACT_ADD;
        else if (p < 60) act = srse_pkg::ACT_REMOVE;
        else if (p < 67) act = srse_pkg::ACT_CLEAR;
        else if (p < 77) act = srse_pkg::ACT_CONTAINS;
        else if (p < 87) act = srse_pkg::ACT_LBOUND;
        else if (p < 95) act = srse_pkg::ACT_HIST;
        else if (p < 96) act = srse_pkg::ACT_VACATE;
        else act = ACT_NOP;
        st = base + 64'($urandom_range(0, 255)) * 8 + ($urandom_range(0, 9) == 0 ?
             64'($urandom_range(1, 7)) : 64'd0);
        sz = 64'($urandom_range(1, 4)) * 8;
        case ($urandom_range(0, 19))
            0: st = wide_rand();
            1: sz = wide_rand();
            2: sz = 0;
            3: begin st = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40)); end
            4: sz = 64'($urandom_range(1, 7));
            5: sz = 64'($urandom_range(64, 2000));
            default: ;
        endcase
        queue_req(act, st, sz, 6'($urandom_range(0, 63)));
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold each transaction until accepted, predict at acceptance.
    // ------------------------------------------------------------------
    int send_gap;

    always @(posedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                rq.action = s_action;
                rq.start = s_range_start;
                rq.size = s_range_size;
                rq.bin = s_bin_index;
                expected_replies.push_back(predict_reply(rq));
                reqs_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_action <= rq.action;
                s_range_start <= rq.start;
                s_range_size <= rq.size;
                s_bin_index <= rq.bin;
                s_valid <= 1'b1;
                // Keep back-to-back stretches: no gap at all for a while.
                send_gap <= (reqs_sent % 400 < 60) ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls plus one long hold-off so the output
    // register fills and the block stalls its input.
    // ------------------------------------------------------------------
    int  hold_cycles;
    bit  long_hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && replies_seen >= 300) begin
            long_hold_done <= 1'b1;
            hold_cycles <= 1500;
            m_ready <= 1'b0;
        end else if (replies_seen % 500 < 80) begin
            m_ready <= 1'b1;
        end else begin
            hold_cycles <= (m_ready && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result transaction, status %0d", m_status);
            end else begin
                exp_r = expected_replies.pop_front();
                if (m_status !== exp_r.status || m_found !== exp_r.found ||
                    m_found_start !== exp_r.fstart || m_found_size !== exp_r.fsize ||
                    m_bin_count !== exp_r.bcount || m_total_space !== exp_r.total ||
                    m_segment_count !== exp_r.segcnt) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: result %0d mismatch", replies_seen);
                        $display("  exp st=%0d f=%0d fs=%h fz=%h bc=%0d tot=%h n=%0d",
                                 exp_r.status, exp_r.found, exp_r.fstart, exp_r.fsize,
                                 exp_r.bcount, exp_r.total, exp_r.segcnt);
                        $display("  got st=%0d f=%0d fs=%h fz=%h bc=%0d tot=%h n=%0d",
                                 m_status, m_found, m_found_start, m_found_size,
                                 m_bin_count, m_total_space, m_segment_count);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    int idle_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        seg_used = 0;
        covered = '0;
        foreach (size_hist[b]) size_hist[b] = 0;

        // Directed: errors, every merge shape, trims and splits, lookups.
        queue_req(srse_pkg::ACT_ADD, 64'd100, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd100, 64'd10, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd120, 64'd10, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd110, 64'd10, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd130, 64'd10, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd90, 64'd10, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd95, 64'd1, 6'd0);
        queue_req(srse_pkg::ACT_CONTAINS, 64'd95, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_CONTAINS, 64'd90, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_CONTAINS, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF, 6'd0);
        queue_req(srse_pkg::ACT_LBOUND, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        queue_req(srse_pkg::ACT_LBOUND, 64'd200, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_HIST, 64'd0, 64'd0, 6'd5);
        queue_req(srse_pkg::ACT_REMOVE, 64'd100, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_REMOVE, 64'd500, 64'd4, 6'd0);
        queue_req(srse_pkg::ACT_REMOVE, 64'd90, 64'd5, 6'd0);
        queue_req(srse_pkg::ACT_REMOVE, 64'd135, 64'd5, 6'd0);
        queue_req(srse_pkg::ACT_REMOVE, 64'd110, 64'd3, 6'd0);
        queue_req(srse_pkg::ACT_CLEAR, 64'd100, 64'd0, 6'd0);
        queue_req(srse_pkg::ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFE, 64'd5, 6'd0);
        queue_req(srse_pkg::ACT_CLEAR, 64'd98, 64'd20, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        queue_req(srse_pkg::ACT_HIST, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        queue_req(ACT_NOP, 64'd1, 64'd1, 6'd1);
        queue_req(srse_pkg::ACT_VACATE, 64'd0, 64'd0, 6'd0);

        // Fill the table past capacity with isolated ranges, then exercise
        // full-table refusals and merges that still fit.
        for (int k = 0; k < 260; k++)
            queue_req(srse_pkg::ACT_ADD, 64'(k) * 32, 64'd16, 6'd0);
        queue_req(srse_pkg::ACT_REMOVE, 64'd36, 64'd4, 6'd0);
        queue_req(srse_pkg::ACT_CLEAR, 64'd68, 64'd4, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd16, 64'd16, 6'd0);
        queue_req(srse_pkg::ACT_ADD, 64'd48, 64'd4, 6'd0);
        for (int k = 0; k < 7; k++)
            queue_req(srse_pkg::ACT_HIST, 64'd0, 64'd0, 6'(k));
        queue_req(srse_pkg::ACT_CLEAR, 64'd1000, 64'd3000, 6'd0);
        queue_req(srse_pkg::ACT_VACATE, 64'd0, 64'd0, 6'd0);

        // Random traffic near zero and near the top of the space.
        for (int k = 0; k < 1500; k++)
            queue_random_req(($urandom_range(0, 4) == 0) ? 64'hFFFF_FFFF_FFFF_C000 : 64'd0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (reqs_sent == reqs_total && expected_replies.size() == 0);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
